[rtl/ltmfe_pkg.sv]
// types, codes and frame constants shared by the telemetry frame encoder
`default_nettype none

package ltmfe_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_GPS  = 2'd1,
    OP_SENS = 2'd2,
    OP_ATT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    FRAME_G = 2'd0,
    FRAME_S = 2'd1,
    FRAME_A = 2'd2
  } frame_kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } ctrl_state_e;

  typedef logic [4:0] byte_idx_t;

  localparam logic [7:0]  SYNC0        = 8'h24;
  localparam logic [7:0]  SYNC1        = 8'h54;
  localparam logic [7:0]  ID_G         = 8'h47;
  localparam logic [7:0]  ID_S         = 8'h53;
  localparam logic [7:0]  ID_A         = 8'h41;
  localparam logic [15:0] LEN_G        = 16'd18;
  localparam logic [15:0] LEN_S        = 16'd11;
  localparam logic [15:0] LEN_A        = 16'd10;
  localparam logic [15:0] PERIOD_RESET = 16'd100;
  localparam logic [7:0]  FIX_MAX      = 8'd3;
  localparam logic [3:0]  SLOT_LAST    = 4'd9;
  localparam logic [3:0]  SLOT_RESTART = 4'd1;
  localparam int          PAY_BYTES    = 15;

  typedef struct packed {
    logic take_item;
    logic emit_byte;
  } cmd_t;

  typedef struct packed {
    logic start_frame;
    logic last_byte;
    logic out_free;
  } status_t;

  function automatic logic [15:0] frame_len(frame_kind_e kind);
    logic [15:0] len;
    case (kind)
      FRAME_G: len = LEN_G;
      FRAME_S: len = LEN_S;
      FRAME_A: len = LEN_A;
      default: len = LEN_A;
    endcase
    return len;
  endfunction

  function automatic byte_idx_t frame_last_idx(frame_kind_e kind);
    logic [15:0] last;
    last = frame_len(kind) - 16'd1;
    return last[4:0];
  endfunction

endpackage

`default_nettype wire

[rtl/ltm_telemetry_frame_encoder_unit.sv]
// top level of the telemetry frame encoder
//
//  channel   direction  handshake                     payload
//  in        input      in_valid_i / in_stall_o       op, time_ms, tx_space, value_a..c,
//                                                     byte_d..f, flag_bits
//  out       output     out_valid_o / out_stall_i     frame_byte, frame_end
//  cfg       input      cfg_valid_i / cfg_ready_o     cfg_data_i (frame period, ms)
//
// load items and ticks that send nothing keep the controller idle, so the next item is not stalled
// a tick that sends a frame emits one byte per cycle while the output is not stalled:
// 18 (G), 11 (S) or 10 (A), from the single output byte register, which a stall holds;
// the next item is taken with the last byte, and output stalls pause the frame
// reset clears all samples, the slot counter and the frame time; period resets to 100
`default_nettype none

module ltm_telemetry_frame_encoder_unit
  import ltmfe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [1:0]  op_i,
  input  logic        [31:0] time_ms_i,
  input  logic        [15:0] tx_space_i,
  input  logic signed [31:0] value_a_i,
  input  logic signed [31:0] value_b_i,
  input  logic signed [31:0] value_c_i,
  input  logic        [7:0]  byte_d_i,
  input  logic        [7:0]  byte_e_i,
  input  logic        [7:0]  byte_f_i,
  input  logic        [1:0]  flag_bits_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [7:0]  frame_byte_o,
  output logic               frame_end_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [15:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  ltmfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ltmfe_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .op_i         (op_i),
    .time_ms_i    (time_ms_i),
    .tx_space_i   (tx_space_i),
    .value_a_i    (value_a_i),
    .value_b_i    (value_b_i),
    .value_c_i    (value_c_i),
    .byte_d_i     (byte_d_i),
    .byte_e_i     (byte_e_i),
    .byte_f_i     (byte_f_i),
    .flag_bits_i  (flag_bits_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .frame_byte_o (frame_byte_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

`default_nettype wire

[rtl/ltmfe_ctrl.sv]
// controller: item acceptance and byte emission sequencing
`default_nettype none

module ltmfe_ctrl
  import ltmfe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        ready;
  logic        emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    emit  = (state_q == ST_EMIT) && status_i.out_free;
    ready = (state_q == ST_IDLE) || (emit && status_i.last_byte);
    cmd_o.emit_byte = emit;
    cmd_o.take_item = in_valid_i && ready;
    in_stall_o      = !ready;
    state_d         = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.take_item && status_i.start_frame) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit && status_i.last_byte) begin
          if (cmd_o.take_item && status_i.start_frame) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/ltmfe_dp.sv]
// datapath: sample registers, frame scheduling, byte mux, checksum, output register
`default_nettype none

module ltmfe_dp
  import ltmfe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic               cfg_we_i,
  input  logic        [15:0] cfg_data_i,
  input  logic        [1:0]  op_i,
  input  logic        [31:0] time_ms_i,
  input  logic        [15:0] tx_space_i,
  input  logic signed [31:0] value_a_i,
  input  logic signed [31:0] value_b_i,
  input  logic signed [31:0] value_c_i,
  input  logic        [7:0]  byte_d_i,
  input  logic        [7:0]  byte_e_i,
  input  logic        [7:0]  byte_f_i,
  input  logic        [1:0]  flag_bits_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic        [7:0]  frame_byte_o,
  output logic               frame_end_o
);

  logic [15:0] period_q;
  logic [31:0] gps_lat_q, gps_lon_q, gps_alt_q;
  logic [7:0]  gps_speed_q, gps_sats_q, gps_fix_q;
  logic [15:0] sens_volt_q, sens_amp_q;
  logic [7:0]  sens_rssi_q, sens_airspeed_q, sens_mode_q;
  logic [1:0]  sens_flags_q;
  logic [15:0] att_pitch_q, att_roll_q, att_heading_q;
  logic [3:0]  slot_q, slot_d;
  logic [31:0] last_time_q;

  frame_kind_e kind_q, kind_new;
  byte_idx_t   idx_q;
  logic [7:0]  crc_q;

  logic        out_valid_q, out_end_q;
  logic [7:0]  out_byte_q;

  op_e                    op;
  logic [31:0]            elapsed;
  logic                   tick, due;
  logic [1:0]             fix_clamped;
  logic [PAY_BYTES*8-1:0] pay_g, pay_s, pay_a, pay_sel;
  logic [3:0]             pay_ofs;
  logic [4:0]             pay_tmp;
  logic [7:0]             byte_cur;
  logic                   is_last;

  always_comb begin
    op      = op_e'(op_i);
    tick    = (op == OP_TICK);
    elapsed = time_ms_i - last_time_q;
    due     = tick && (elapsed >= {16'd0, period_q});
    if (slot_q[0]) begin
      kind_new = FRAME_A;
    end else if (slot_q[1:0] == 2'b00) begin
      kind_new = FRAME_S;
    end else begin
      kind_new = FRAME_G;
    end
    slot_d = (slot_q == SLOT_LAST) ? SLOT_RESTART : slot_q + 4'd1;

    fix_clamped = (gps_fix_q > FIX_MAX) ? FIX_MAX[1:0] : gps_fix_q[1:0];
    pay_g = {8'd0, gps_sats_q[5:0], fix_clamped, gps_alt_q, gps_speed_q, gps_lon_q, gps_lat_q};
    pay_s = {64'd0, sens_mode_q[5:0], sens_flags_q, sens_airspeed_q, sens_rssi_q,
             sens_amp_q, sens_volt_q};
    pay_a = {72'd0, att_heading_q, att_roll_q, att_pitch_q};
    case (kind_q)
      FRAME_G: pay_sel = pay_g;
      FRAME_S: pay_sel = pay_s;
      FRAME_A: pay_sel = pay_a;
      default: pay_sel = pay_a;
    endcase
    pay_tmp = idx_q - 5'd3;
    pay_ofs = pay_tmp[3:0];
    is_last = (idx_q == frame_last_idx(kind_q));

    if (is_last) begin
      byte_cur = crc_q;
    end else if (idx_q == 5'd0) begin
      byte_cur = SYNC0;
    end else if (idx_q == 5'd1) begin
      byte_cur = SYNC1;
    end else if (idx_q == 5'd2) begin
      case (kind_q)
        FRAME_G: byte_cur = ID_G;
        FRAME_S: byte_cur = ID_S;
        FRAME_A: byte_cur = ID_A;
        default: byte_cur = ID_A;
      endcase
    end else begin
      byte_cur = pay_sel[{pay_ofs, 3'b000} +: 8];
    end

    status_o.start_frame = due && (tx_space_i >= frame_len(kind_new));
    status_o.last_byte   = is_last;
    status_o.out_free    = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q        <= PERIOD_RESET;
      gps_lat_q       <= '0;
      gps_lon_q       <= '0;
      gps_alt_q       <= '0;
      gps_speed_q     <= '0;
      gps_sats_q      <= '0;
      gps_fix_q       <= '0;
      sens_volt_q     <= '0;
      sens_amp_q      <= '0;
      sens_rssi_q     <= '0;
      sens_airspeed_q <= '0;
      sens_mode_q     <= '0;
      sens_flags_q    <= '0;
      att_pitch_q     <= '0;
      att_roll_q      <= '0;
      att_heading_q   <= '0;
      slot_q          <= '0;
      last_time_q     <= '0;
      kind_q          <= FRAME_G;
      idx_q           <= '0;
      crc_q           <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_data_i;
      end
      if (cmd_i.emit_byte) begin
        out_valid_q <= 1'b1;
        if (!(cmd_i.take_item && status_o.start_frame)) begin
          idx_q <= idx_q + 5'd1;
        end
        if (idx_q > 5'd2 && !is_last) begin
          crc_q <= crc_q ^ byte_cur;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.take_item) begin
        case (op)
          OP_GPS: begin
            gps_lat_q   <= value_a_i;
            gps_lon_q   <= value_b_i;
            gps_alt_q   <= value_c_i;
            gps_speed_q <= byte_d_i;
            gps_sats_q  <= byte_e_i;
            gps_fix_q   <= byte_f_i;
          end
          OP_SENS: begin
            sens_volt_q     <= value_a_i[15:0];
            sens_amp_q      <= value_b_i[15:0];
            sens_rssi_q     <= byte_d_i;
            sens_airspeed_q <= byte_e_i;
            sens_mode_q     <= byte_f_i;
            sens_flags_q    <= flag_bits_i;
          end
          OP_ATT: begin
            att_pitch_q   <= value_a_i[15:0];
            att_roll_q    <= value_b_i[15:0];
            att_heading_q <= value_c_i[15:0];
          end
          OP_TICK: begin
            if (due) begin
              last_time_q <= time_ms_i;
              slot_q      <= slot_d;
              if (status_o.start_frame) begin
                kind_q <= kind_new;
                idx_q  <= '0;
                crc_q  <= '0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_byte) begin
      out_byte_q <= byte_cur;
      out_end_q  <= is_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign frame_end_o  = out_end_q;

endmodule

`default_nettype wire

[rtl/ltmfe_checker.sv]
// port-level checker for the telemetry frame encoder and its bind
`default_nettype none

module ltmfe_checker
  import ltmfe_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] frame_byte_o,
  input logic       frame_end_o
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_byte_o) && $stable(frame_end_o))
    else $error("stalled output item changed");

  a_sync_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && frame_end_o |=> !out_valid_o || frame_byte_o == SYNC0)
    else $error("frame does not start with sync byte");

  a_stall_while_sending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && !frame_end_o |-> in_stall_o)
    else $error("item taken in the middle of a frame");

endmodule

bind ltm_telemetry_frame_encoder_unit ltmfe_checker u_ltmfe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .frame_byte_o (frame_byte_o),
  .frame_end_o  (frame_end_o)
);

`default_nettype wire
